// ----- rtl/coverage_bitmap_novelty_check_unit_macros.svh -----
// Assertion macros shared by the novelty check unit checker.
`ifndef COVERAGE_BITMAP_NOVELTY_CHECK_UNIT_MACROS_SVH
`define COVERAGE_BITMAP_NOVELTY_CHECK_UNIT_MACROS_SVH

// Check a same-cycle implication on every clock edge outside reset.
`define CBNC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication that must hold on the following clock edge.
`define CBNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cbnc_pkg.sv -----
// Shared constants, types and helpers for the coverage novelty check unit.
`timescale 1ns / 1ps

package cbnc_pkg;

  // Virgin map geometry
  localparam int MAP_WORDS = 8192;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int WORD_W    = 64;
  localparam int IDX_W     = 13;
  localparam int BYTES     = WORD_W / 8;

  // Stream payload widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 8;
  localparam int RES_W       = 3;

  // Result queue geometry
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  // Novelty classes
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_COUNT = 2'd1,
    CLS_TUPLE = 2'd2
  } class_t;

  // True when a nonzero hit byte lands on a fully virgin byte
  function automatic logic fresh_byte_hit(input logic [WORD_W-1:0] hits,
                                          input logic [WORD_W-1:0] virgin);
    logic found;
    found = 1'b0;
    for (int b = 0; b < BYTES; b++) begin
      if ((hits[8*b +: 8] != 8'h00) && (virgin[8*b +: 8] == 8'hff)) begin
        found = 1'b1;
      end
    end
    return found;
  endfunction

endpackage

// ----- rtl/coverage_bitmap_novelty_check_unit.sv -----
// Top level: virgin map read-modify-write and per-run novelty classification.
//
// Channel  | Dir | Payload (low bit first)                           | Sideband
// ---------+-----+---------------------------------------------------+----------------
// s_axis   | in  | trace_word[63:0], word_index[76:64], zero pad     | tlast=last_word
// m_axis   | out | novelty_class[1:0], map_changed[2], zero pad      | -
//
// One trace word per cycle while s_axis_tready is high: read the virgin word
// in the accept cycle, modify and write it back in the next; a one-entry
// forward covers back-to-back hits on the same word. Each result passes through
// the modify stage and into the result queue before it appears on m_axis.
// After reset a clearing pass over all MAP_WORDS (8192) words fills the virgin
// map with ones; s_axis_tready stays low throughout it. A four-entry result
// queue absorbs output stalls; input also stalls when that queue could overflow.
`timescale 1ns / 1ps

module coverage_bitmap_novelty_check_unit
  import cbnc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // trace_word[63:0], word_index[76:64], zero [79:77]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // novelty_class[1:0], map_changed[2], zero [7:3]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Input field split
  logic [WORD_W-1:0] in_word;
  logic [IDX_W-1:0]  in_index;
  logic              in_accept;
  logic              in_map;
  logic [ADDR_W-1:0] in_addr;

  assign in_word   = s_axis_tdata[WORD_W-1:0];
  assign in_index  = s_axis_tdata[WORD_W +: IDX_W];
  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign in_map    = (32'(in_index) < MAP_WORDS);
  assign in_addr   = ADDR_W'(in_index);

  // Clearing pass counter
  logic [ADDR_W:0] clr_cnt;
  logic            clearing;

  assign clearing = (clr_cnt != (ADDR_W+1)'(MAP_WORDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Virgin map memory
  logic [WORD_W-1:0] virgin_mem [MAP_WORDS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      virgin_mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_data <= virgin_mem[in_addr];
    end
  end

  // Modify stage registers
  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_in_map;
  logic              s1_last;
  logic              fwd_hit;
  logic [WORD_W-1:0] fwd_data;

  // Modify stage logic
  logic [WORD_W-1:0] virgin_cur;
  logic [WORD_W-1:0] virgin_new;
  logic              overlap;
  logic              s1_wr;
  class_t            running_class;
  class_t            running_class_next;
  class_t            class_upd;

  assign virgin_cur = fwd_hit ? fwd_data : rd_data;
  assign virgin_new = virgin_cur & ~s1_word;
  assign overlap    = s1_in_map & (|(s1_word & virgin_cur));
  assign s1_wr      = s1_valid & s1_in_map;

  // Raise the running class on an overlap, unless already at new tuple; restart at none after a run's last word
  always_comb begin
    class_upd = running_class;
    if (overlap && (running_class != CLS_TUPLE)) begin
      class_upd = fresh_byte_hit(s1_word, virgin_cur) ? CLS_TUPLE : CLS_COUNT;
    end
    running_class_next = running_class;
    if (s1_valid) begin
      running_class_next = s1_last ? CLS_NONE : class_upd;
    end
  end

  // Memory write port: clearing pass first, then write-back
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt[ADDR_W-1:0];
      mem_wdata = '1;
    end else begin
      mem_we    = s1_wr;
      mem_waddr = s1_addr;
      mem_wdata = virgin_new;
    end
  end

  // Advance the modify stage and capture the forward path
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      running_class <= CLS_NONE;
    end else begin
      s1_valid      <= in_accept;
      running_class <= running_class_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word   <= in_word;
      s1_addr   <= in_addr;
      s1_in_map <= in_map;
      s1_last   <= s_axis_tlast;
      fwd_hit   <= s1_wr & (s1_addr == in_addr);
      fwd_data  <= virgin_new;
    end
  end

  // Result queue
  logic [RES_W-1:0]   res_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_PTR_W:0]   res_cnt;
  logic                 res_push;
  logic                 res_pop;
  logic                 last_pending;

  assign res_push     = s1_valid & s1_last;
  assign res_pop      = m_axis_tvalid & m_axis_tready;
  assign last_pending = s1_valid & s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      res_cnt <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (res_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      res_cnt <= res_cnt + (OUT_PTR_W+1)'(res_push) - (OUT_PTR_W+1)'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q[wr_ptr] <= {class_upd != CLS_NONE, class_upd};
    end
  end

  // Hold input during the clearing pass and while the queue could not take one more result
  assign s_axis_tready = !clearing &&
    (((OUT_PTR_W+2)'(res_cnt) + (OUT_PTR_W+2)'(last_pending)) < (OUT_PTR_W+2)'(OUT_DEPTH));

  assign m_axis_tvalid = (res_cnt != '0);
  assign m_axis_tdata  = {(OUT_TDATA_W-RES_W)'(0), res_q[rd_ptr]};

endmodule

// ----- rtl/cbnc_checker.sv -----
// Port-level checker for the coverage novelty check unit, bound to the top level.
`timescale 1ns / 1ps
`include "coverage_bitmap_novelty_check_unit_macros.svh"

module cbnc_checker
  import cbnc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Map-changed flag must agree with the reported class
  `CBNC_ASSERT_SAME(a_changed_match, m_axis_tvalid, m_axis_tdata[RES_W-1] == (m_axis_tdata[1:0] != CLS_NONE), "map_changed disagrees with novelty_class")

  // Padding above the result fields stays zero
  `CBNC_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:RES_W] == '0, "nonzero padding in result")

  // The clearing pass keeps the input closed right after reset
  `CBNC_ASSERT_SAME(a_clear_after_reset, $past(rst), !s_axis_tready, "input open during clearing pass")

  // A stalled result holds
  `CBNC_ASSERT_NEXT(a_result_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind coverage_bitmap_novelty_check_unit cbnc_checker u_cbnc_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the coverage bitmap novelty check unit.
`timescale 1ns / 1ps

module tb
  import cbnc_pkg::*;
;

  localparam int ITEM_TARGET = 750;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int DRAIN_LIMIT = 4000;
  localparam int RUN_LIMIT_NS = 600000;

  // expected outcome of one trace run
  typedef struct packed {
    class_t cls;
    logic   changed;
  } run_outcome_t;

  // Tracks the virgin map and the class of the open run; holds run outcomes
  class novelty_scoreboard;
    logic [WORD_W-1:0] virgin [int];
    class_t            run_class;
    run_outcome_t      pending [$];
    int                mismatches;
    int                tally [3];

    function new();
      run_class = CLS_NONE;
      mismatches = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    // any nonzero hit byte landing on an untouched virgin byte
    function bit lands_on_fresh_byte(logic [WORD_W-1:0] hits, logic [WORD_W-1:0] map_word);
      bit hit;
      hit = 1'b0;
      for (int lane = 0; lane < BYTES; lane++) begin
        if (hits[8*lane +: 8] != 8'h00 && map_word[8*lane +: 8] == 8'hff) hit = 1'b1;
      end
      return hit;
    endfunction

    // Update map and class for one accepted trace word
    function void note_input(logic [WORD_W-1:0] trace, logic [IDX_W-1:0] idx, logic last);
      logic [WORD_W-1:0] map_word;
      run_outcome_t      outcome;
      if (int'(idx) < MAP_WORDS && trace != '0) begin
        map_word = virgin.exists(int'(idx)) ? virgin[int'(idx)] : '1;
        if ((trace & map_word) != '0) begin
          if (run_class != CLS_TUPLE)
            run_class = lands_on_fresh_byte(trace, map_word) ? CLS_TUPLE : CLS_COUNT;
          virgin[int'(idx)] = map_word & ~trace;
        end
      end
      if (last) begin
        outcome.cls = run_class;
        outcome.changed = (run_class != CLS_NONE);
        pending.insert(pending.size(), outcome);
        run_class = CLS_NONE;
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Compare one accepted result against the oldest pending run
    task check_result(logic [OUT_TDATA_W-1:0] data);
      run_outcome_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with no run pending", data));
      end else begin
        want = pending.pop_front();
        if (want.cls <= CLS_TUPLE) tally[want.cls]++;
        if (data[1:0] != want.cls)
          report_mismatch($sformatf("novelty class %0d, expected %0d", data[1:0], want.cls));
        if (data[2] != want.changed)
          report_mismatch($sformatf("map changed %0b, expected %0b", data[2], want.changed));
        if (data[OUT_TDATA_W-1:3] != '0)
          report_mismatch($sformatf("nonzero pad bits in result 0x%02h", data));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  novelty_scoreboard sb = new();
  bit steady = 1'b0;
  bit hold_start = 1'b0;
  int items_sent = 0;
  int runs_sent = 0;

  coverage_bitmap_novelty_check_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one trace word, wait for its request to be taken, then record it
  task automatic send_item(input logic [WORD_W-1:0] trace, input logic [IDX_W-1:0] idx,
                           input logic last);
    if (!steady && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 27);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - WORD_W - IDX_W){1'b0}}, idx, trace};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(trace, idx, last);
    items_sent++;
    if (last) runs_sent++;
  endtask

  // Result side: check accepted results, idle at random, honor hold-off requests
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_start) begin
        hold_left = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 27);
      end
    end
  end

  // Hard stop if the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("[%0t] run limit reached with %0d runs pending", $time, sb.pending.size());
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    logic [WORD_W-1:0] trace;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        hit_byte;
    int                pool_base;
    int                run_len;
    int                lanes;
    int                n;
    bit                pressure_done;

    pool_base = 0;
    pressure_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero word, full word at the top index, repeat with no overlap
    send_item(64'h0, 13'd0, 1'b1);
    send_item('1, 13'h1fff, 1'b1);
    send_item('1, 13'h1fff, 1'b1);
    // new tuple, then new hit count on the same byte
    send_item(64'h01, 13'd5, 1'b1);
    send_item(64'h02, 13'd5, 1'b1);
    // class already at tuple: byte test skipped, bits still cleared
    send_item(64'h80, 13'd6, 1'b0);
    send_item(64'h04, 13'd5, 1'b0);
    send_item(64'h08, 13'd5, 1'b1);
    send_item(64'h0c, 13'd5, 1'b1);
    // running maximum rises from hit count to tuple
    send_item(64'h10, 13'd5, 1'b0);
    send_item(64'h100, 13'd7, 1'b1);
    // consecutive words on one index
    send_item(64'h01, 13'd9, 1'b0);
    send_item(64'h01, 13'd9, 1'b0);
    send_item(64'h03, 13'd9, 1'b1);
    send_item(64'h01, 13'd10, 1'b1);
    send_item(64'h02, 13'd10, 1'b1);
    send_item(64'h02, 13'd10, 1'b1);
    // top byte lane, then a hit count in the same lane
    send_item(64'h8000_0000_0000_0000, 13'd11, 1'b1);
    send_item(64'h0100_0000_0000_0000, 13'd11, 1'b1);
    // run with nothing new, ending on a zero word
    send_item(64'h8000_0000_0000_0000, 13'd11, 1'b0);
    send_item('1, 13'h1fff, 1'b0);
    send_item(64'h0, 13'd12, 1'b1);
    // alternating bit patterns over the whole word
    send_item(64'haaaa_aaaa_aaaa_aaaa, 13'h0aaa, 1'b0);
    send_item(64'h5555_5555_5555_5555, 13'h1555, 1'b1);

    // Random runs over a small moving pool of map words, so bytes get reused
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(7) == 0) pool_base = $urandom_range(0, MAP_WORDS - 16);
      steady = (items_sent >= 450 && items_sent < 600);

      // Stall the result side and keep offering one-word runs so the input backs up
      if (!pressure_done && items_sent >= 350) begin
        pressure_done = 1'b1;
        hold_start = 1'b1;
        for (int k = 0; k < 24; k++) begin
          idx = IDX_W'(pool_base + $urandom_range(0, 15));
          send_item(64'h1 << $urandom_range(0, 63), idx, 1'b1);
        end
      end

      run_len = $urandom_range(1, 12);
      for (int k = 0; k < run_len; k++) begin
        case ($urandom_range(9))
          0: trace = '0;
          1: trace = {$urandom(), $urandom()};
          2: trace = '1;
          3: trace = 64'h1 << $urandom_range(0, 63);
          default: begin
            trace = '0;
            lanes = $urandom_range(1, 3);
            for (int b = 0; b < lanes; b++) begin
              hit_byte = ($urandom_range(2) == 0) ? 8'($urandom()) : 8'h1 << $urandom_range(0, 7);
              trace[8*$urandom_range(0, BYTES - 1) +: 8] = hit_byte;
            end
          end
        endcase
        case ($urandom_range(9))
          0: idx = IDX_W'($urandom());
          1: idx = IDX_W'(pool_base + 16 + $urandom_range(0, 31));
          default: idx = IDX_W'(pool_base + $urandom_range(0, 15));
        endcase
        send_item(trace, idx, k == run_len - 1);
      end
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    // Drain outstanding results, then let the pipeline settle
    for (n = 0; n < DRAIN_LIMIT && sb.pending.size() != 0; n++) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d runs never reported", sb.pending.size()));
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d trace words in %0d runs, including a %0d-cycle output stall.",
             items_sent, runs_sent, HOLD_CYCLES);
    $display("Runs checked by class: nothing new %0d, new hit count %0d, new tuple %0d.",
             sb.tally[0], sb.tally[1], sb.tally[2]);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
